[design/rnd_pkg.sv]
// rnd_pkg: types, constants and helper functions of the roman numeral decoder
// used by the interfaces, front, queue, back and top level; no dependencies

package rnd_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned VALUE_W     = 15;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ACC_W       = 16;
  localparam int unsigned LVAL_W      = 11;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0]       REPEAT_MAX = 2'd3;
  localparam logic [ACC_W-1:0] ACC_MAX    = 16'h7fff;
  localparam logic [ACC_W-1:0] ACC_MIN    = 16'h8000;

  // codes are ordered by letter value so codes compare like values
  typedef enum logic [2:0] {
    LET_NONE,
    LET_I,
    LET_V,
    LET_X,
    LET_L,
    LET_C,
    LET_D,
    LET_M
  } letter_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef struct packed {
    letter_e letter;
    logic    last;
  } token_t;

  function automatic letter_e classify(input logic [CH_W-1:0] ch);
    letter_e l;
    unique case (ch)
      8'h49:   l = LET_I;
      8'h56:   l = LET_V;
      8'h58:   l = LET_X;
      8'h4c:   l = LET_L;
      8'h43:   l = LET_C;
      8'h44:   l = LET_D;
      8'h4d:   l = LET_M;
      default: l = LET_NONE;
    endcase
    return l;
  endfunction

  function automatic logic [LVAL_W-1:0] letter_value(input letter_e l);
    logic [LVAL_W-1:0] v;
    unique case (l)
      LET_I:   v = 11'd1;
      LET_V:   v = 11'd5;
      LET_X:   v = 11'd10;
      LET_L:   v = 11'd50;
      LET_C:   v = 11'd100;
      LET_D:   v = 11'd500;
      LET_M:   v = 11'd1000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic pair_forbidden(input letter_e a, input letter_e b);
    logic f;
    unique case (a)
      LET_I:   f = (b == LET_L) || (b == LET_C) || (b == LET_D) || (b == LET_M);
      LET_V:   f = (b == LET_V) || (b == LET_X) || (b == LET_L) || (b == LET_C) ||
                   (b == LET_D) || (b == LET_M);
      LET_X:   f = (b == LET_D) || (b == LET_M);
      LET_L:   f = (b == LET_L) || (b == LET_C) || (b == LET_D) || (b == LET_M);
      LET_D:   f = (b == LET_D) || (b == LET_M);
      default: f = 1'b0;
    endcase
    return f;
  endfunction

  // clamp a 17-bit two's complement sum to the 16-bit accumulator range
  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] s);
    logic [ACC_W-1:0] r;
    priority if (!s[ACC_W] && s[ACC_W-1]) begin
      r = ACC_MAX;
    end else if (s[ACC_W] && !s[ACC_W-1]) begin
      r = ACC_MIN;
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/rnd_if.sv]
// rnd_char_if and rnd_res_if: valid/ready channels of the roman numeral decoder
// depends on rnd_pkg for the field widths

interface rnd_char_if;
  logic                       valid;
  logic                       ready;
  logic [rnd_pkg::CH_W-1:0]   ch;
  logic                       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface rnd_res_if;
  logic                           valid;
  logic                           ready;
  logic [rnd_pkg::VALUE_W-1:0]    value;
  logic [rnd_pkg::STATUS_W-1:0]   status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

[design/rnd_front.sv]
// rnd_front: accepts characters, classifies them into letter codes, registers them
// depends on rnd_pkg and rnd_char_if

module rnd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  rnd_char_if.sink        in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output rnd_pkg::token_t push_token_o
);
  import rnd_pkg::*;

  logic   vld_q, vld_d;
  token_t tok_q;
  logic   in_fire;

  assign in_i.ready = !vld_q || push_ready_i;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (push_ready_i) begin
      vld_d = 1'b0;
    end
    if (in_fire) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tok_q.letter <= classify(in_i.ch);
      tok_q.last   <= in_i.last;
    end
  end

  assign push_valid_o = vld_q;
  assign push_token_o = tok_q;

endmodule

[design/rnd_queue.sv]
// rnd_queue: short first-in first-out queue of letter tokens between front and back
// depends on rnd_pkg

module rnd_queue #(
  parameter int unsigned Depth = rnd_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rnd_pkg::token_t push_token_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output rnd_pkg::token_t pop_token_o
);
  import rnd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  token_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign push         = push_valid_i && push_ready_o;
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_token_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not grow on push");

endmodule

[design/rnd_back.sv]
// rnd_back: pair checks, saturating accumulation and result register
// depends on rnd_pkg and rnd_res_if

module rnd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  rnd_pkg::token_t tok_i,
  output logic            pop_o,
  rnd_res_if.source       out_o
);
  import rnd_pkg::*;

  logic             have_prev_q, have_prev_d;
  letter_e          prev_q, prev_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [1:0]       rep_q, rep_d;
  logic             after_q, after_d;
  logic             bad_q, bad_d;
  logic             mal_q, mal_d;

  logic               out_vld_q, out_vld_d;
  logic [VALUE_W-1:0] value_q, value_d;
  status_e            status_q, status_d;

  letter_e           cur;
  logic [LVAL_W-1:0] vp;
  logic [ACC_W:0]    delta;
  logic [ACC_W:0]    sum;
  logic [1:0]        rep_inc;
  logic [ACC_W:0]    total;

  assign pop_o   = tok_valid_i && (!out_vld_q || out_o.ready);
  assign cur     = tok_i.letter;
  assign vp      = letter_value(prev_q);
  assign delta   = (prev_q >= cur) ? {{(ACC_W + 1 - LVAL_W){1'b0}}, vp}
                                   : -{{(ACC_W + 1 - LVAL_W){1'b0}}, vp};
  assign sum     = {acc_q[ACC_W-1], acc_q} + delta;
  assign rep_inc = (rep_q == REPEAT_MAX) ? rep_q : rep_q + 2'd1;

  always_comb begin
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    acc_d       = acc_q;
    rep_d       = rep_q;
    after_d     = after_q;
    bad_d       = bad_q;
    mal_d       = mal_q;
    out_vld_d   = out_vld_q;
    value_d     = value_q;
    status_d    = status_q;
    total       = '0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    if (pop_o) begin
      if (cur == LET_NONE) begin
        bad_d = 1'b1;
      end else begin
        if (have_prev_q) begin
          if (!mal_q) begin
            priority if (pair_forbidden(prev_q, cur)) begin
              mal_d = 1'b1;
            end else if (prev_q == cur) begin
              rep_d = rep_inc;
              if ((rep_inc == REPEAT_MAX && !after_q) || (rep_inc == 2'd1 && after_q)) begin
                mal_d = 1'b1;
              end
            end else if (prev_q > cur) begin
              after_d = 1'b0;
              rep_d   = '0;
            end else begin
              if (rep_q == 2'd1) begin
                mal_d = 1'b1;
              end
              after_d = 1'b1;
              rep_d   = '0;
            end
          end
          acc_d = sat_acc(sum);
        end
        prev_d      = cur;
        have_prev_d = 1'b1;
      end

      if (tok_i.last) begin
        total = {acc_d[ACC_W-1], acc_d} +
                (have_prev_d ? {{(ACC_W + 1 - LVAL_W){1'b0}}, letter_value(prev_d)} : '0);
        out_vld_d = 1'b1;
        priority if (bad_d) begin
          status_d = ST_BAD_CHAR;
          value_d  = '0;
        end else if (mal_d) begin
          status_d = ST_MALFORMED;
          value_d  = '0;
        end else begin
          status_d = ST_OK;
          priority if (total[ACC_W]) begin
            value_d = '0;
          end else if (total[ACC_W-1]) begin
            value_d = '1;
          end else begin
            value_d = total[VALUE_W-1:0];
          end
        end
        have_prev_d = 1'b0;
        prev_d      = LET_NONE;
        acc_d       = '0;
        rep_d       = '0;
        after_d     = 1'b0;
        bad_d       = 1'b0;
        mal_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_q      <= LET_NONE;
      acc_q       <= '0;
      rep_q       <= '0;
      after_q     <= 1'b0;
      bad_q       <= 1'b0;
      mal_q       <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      acc_q       <= acc_d;
      rep_q       <= rep_d;
      after_q     <= after_d;
      bad_q       <= bad_d;
      mal_q       <= mal_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.value  = value_q;
  assign out_o.status = status_q;

  a_value_zero_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q != ST_OK |-> value_q == '0)
    else $error("nonzero value with fault status");

  a_state_cleared_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && tok_i.last |=> !have_prev_q && !bad_q && !mal_q && acc_q == '0)
    else $error("numeral state not cleared after final character");

  a_rep_max_is_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q == REPEAT_MAX |-> mal_q)
    else $error("repeat count saturated without malformed flag");

endmodule

[design/roman_numeral_decoder_top.sv]
// roman_numeral_decoder_top: Roman numeral to integer decoder
// depends on rnd_pkg, rnd_if, rnd_front, rnd_queue and rnd_back
//
// in_i carries one ASCII character per transfer, left to right, with last
// high on the final character of a numeral. out_o carries one result per
// numeral: value (15 bits) and status (0 ok, 1 bad character, 2 malformed);
// value is 0 unless status is ok. Characters other than the final one give
// no result.
// Throughput is one character per cycle while out_o.ready is not held low,
// set by the pair check and saturating add in the back end. Between the final
// character's transfer and its result transfer lie the front register, the
// queue and the result register.
// Reset clears all numeral state and empties the queue; the block is ready
// once reset is released, with no clearing pass.
// When the receiver holds out_o.ready low the result register holds, the
// back end stops taking tokens, the queue of QueueDepth entries fills and
// in_i.ready falls; no character or result is lost.

module roman_numeral_decoder_top #(
  parameter int unsigned QueueDepth = rnd_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rnd_char_if.sink  in_i,
  rnd_res_if.source out_o
);
  import rnd_pkg::*;

  logic   push_valid;
  logic   push_ready;
  token_t push_token;
  logic   tok_valid;
  token_t tok;
  logic   pop;

  rnd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_token_o (push_token)
  );

  rnd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_token_i (push_token),
    .pop_valid_o  (tok_valid),
    .pop_i        (pop),
    .pop_token_o  (tok)
  );

  rnd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
